// File: design/fadd_pkg.sv
`default_nettype none
package fadd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SumW = 27;

  // Leading-one distance below bit 25 of a 27-bit value; zero when none is set.
  function automatic logic [4:0] lead_shift(input logic [SumW-1:0] v);
    logic [4:0] r;
    logic found;
    r = 5'd0;
    found = 1'b0;
    for (int i = 25; i >= 0; i--) begin
      if (!found && v[i]) begin
        r = 5'(25 - i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/float32_adder_top.sv
`default_nettype none
// Single-precision adder: each transaction carries two binary32 words and
// returns their rounded sum. Operands are captured in an input register, the
// whole add is one combinational pass, and the sum sits in an output register,
// so one transaction is accepted every cycle while the output side does not
// stall, and each result passes through the input and then the output register.
module float32_adder_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [fadd_pkg::WordW-1:0] in_operand_a,
  input  wire logic [fadd_pkg::WordW-1:0] in_operand_b,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [fadd_pkg::WordW-1:0] out_sum_bits
);
  import fadd_pkg::*;

  logic s1_valid_r;
  logic [WordW-1:0] a_r, b_r, sum_r, sum_nxt;
  logic s1_ready, out_ready_int;

  assign out_ready_int = !out_valid || out_ready;
  assign s1_ready = !s1_valid_r || out_ready_int;
  assign in_ready = s1_ready;

  fadd_core u_core (.a(a_r), .b(b_r), .y(sum_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (out_ready_int) out_valid <= s1_valid_r;
    end
    if (in_valid && s1_ready) begin
      a_r <= in_operand_a;
      b_r <= in_operand_b;
    end
    if (s1_valid_r && out_ready_int) sum_r <= sum_nxt;
  end

  assign out_sum_bits = sum_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_bits))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_ready_int |=> out_valid)
    else $error("stage one transaction lost");

endmodule
`default_nettype wire

// File: design/fadd_core.sv
`default_nettype none
module fadd_core (
  input  wire logic [fadd_pkg::WordW-1:0] a,
  input  wire logic [fadd_pkg::WordW-1:0] b,
  output logic      [fadd_pkg::WordW-1:0] y
);
  import fadd_pkg::*;

  logic sa, sb, sbig, pick_a, sticky0, sticky, rnd_up;
  logic [7:0] ea, eb, xa, xb, ebig, diff, ez, ey;
  logic [4:0] sh, se;
  logic [22:0] fa, fb, my;
  logic [23:0] ma, mb, mbig, msml;
  logic [54:0] al;
  logic [25:0] top;
  logic [26:0] sum, md, mf;
  logic [8:0] ed;
  logic signed [9:0] ef;
  logic [24:0] mr;

  always_comb begin
    sa = a[31]; ea = a[30:23]; fa = a[22:0];
    sb = b[31]; eb = b[30:23]; fb = b[22:0];
    ma = (ea != 8'd0) ? {1'b1, fa} : {1'b0, fa};
    mb = (eb != 8'd0) ? {1'b1, fb} : {1'b0, fb};
    xa = (ea != 8'd0) ? ea : 8'd1;
    xb = (eb != 8'd0) ? eb : 8'd1;
    diff = (xa > xb) ? xa - xb : xb - xa;
    sh = (diff > 8'd31) ? 5'd31 : diff[4:0];
    pick_a = (sh == 5'd0) ? (ma > mb) : (xa > xb);
    mbig = pick_a ? ma : mb;
    msml = pick_a ? mb : ma;
    ebig = pick_a ? xa : xb;
    sbig = pick_a ? sa : sb;
    al = {msml, 31'd0} >> sh;
    sticky0 = al[28:0] != 29'd0;
    top = al[54:29];
    sum = (sa == sb) ? ({1'b0, mbig, 2'b00} + {1'b0, top})
                     : ({1'b0, mbig, 2'b00} - {1'b0, top});

    if (sum[26]) begin
      if (ebig == 8'd254) begin
        ed = 9'd255; md = 27'h2000000; sticky = 1'b0;
      end else begin
        ed = {1'b0, ebig} + 9'd1; md = sum >> 1; sticky = sticky0 | sum[0];
      end
    end else begin
      ed = {1'b0, ebig}; md = sum; sticky = sticky0;
    end

    se = lead_shift(md);
    ef = $signed({1'b0, ed}) - $signed({5'd0, se});
    ez = (ef > 0) ? ef[7:0] : 8'd0;
    mf = (ef > 0) ? (md << se) : (md << ((ed[4:0] - 5'd1)));

    rnd_up = mf[1] & (mf[0] | (!sticky & mf[2]) | (sticky & (sa == sb)));
    mr = mf[26:2] + {24'd0, rnd_up};

    if (mr[24]) begin
      ey = ez + 8'd1; my = 23'd0;
    end else if (mr[23:0] == 24'd0) begin
      ey = 8'd0; my = 23'd0;
    end else begin
      ey = (ez == 8'd0 && mr[23]) ? 8'd1 : ez;
      my = mr[22:0];
    end

    if (ea == 8'hFF && eb != 8'hFF)
      y = {sa, 8'hFF, fa != 23'd0, fa[21:0]};
    else if (eb == 8'hFF && ea != 8'hFF)
      y = {sb, 8'hFF, fb != 23'd0, fb[21:0]};
    else if (ea == 8'hFF) begin
      if (fa != 23'd0) y = {sa, 8'hFF, 1'b1, fa[21:0]};
      else if (fb != 23'd0) y = {sb, 8'hFF, 1'b1, fb[21:0]};
      else if (sa == sb) y = {sa, 8'hFF, 23'd0};
      else y = 32'hFFC00000;
    end else
      y = {((ey == 8'd0 && my == 23'd0) ? (sa & sb) : sbig), ey, my};
  end

endmodule
`default_nettype wire
